// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/trpp_pkg.sv -----
package trpp_pkg;

    localparam int TRPP_ENTRIES = 16;

    localparam logic [1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_COLLECT = 2'd2;
    localparam logic [1:0] REQ_DROP    = 2'd3;

    localparam logic [2:0] ST_REUSED  = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_FAILED  = 3'd4;
    localparam logic [2:0] ST_RETIRED = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    localparam logic [2:0] MC_NONE   = 3'd0;
    localparam logic [2:0] MC_NOKEY  = 3'd1;
    localparam logic [2:0] MC_BUSY   = 3'd2;
    localparam logic [2:0] MC_FLIGHT = 3'd3;
    localparam logic [2:0] MC_OTHER  = 3'd4;

    localparam logic [7:0] REG_GRANULARITY = 8'd0;
    localparam logic [7:0] REG_BUDGET      = 8'd1;
    localparam logic [7:0] REG_EARLY       = 8'd2;
    localparam logic [7:0] REG_IDLE        = 8'd3;

    localparam logic [12:0] GRAN_RESET   = 13'd64;
    localparam logic [40:0] BUDGET_RESET = 41'd268435456;
    localparam logic [7:0]  IDLE_RESET   = 8'd60;
    localparam logic [14:0] DIM_MAX      = 15'h7FFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] format;
        logic [14:0] width;
        logic [14:0] height;
        logic [31:0] usage;
        logic [63:0] timeline_point;
        logic [34:0] image_bytes;
        logic        create_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [2:0]  miss_cause;
        logic        unsafe_reuse;
        logic [63:0] retire_point;
        logic [14:0] key_width;
        logic [14:0] key_height;
        logic [38:0] bytes_live;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] format;
        logic [14:0] width;
        logic [14:0] height;
        logic [31:0] usage;
        logic [34:0] size;
        logic [63:0] release_point;
        logic [31:0] frame;
        logic        busy;
    } entry_t;

endpackage

// ----- sv/trpp_req_if.sv -----
interface trpp_req_if;
    logic valid;
    logic ready;
    trpp_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/trpp_rsp_if.sv -----
interface trpp_rsp_if;
    logic valid;
    logic ready;
    trpp_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/trpp_cfg_if.sv -----
interface trpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  addr;
    logic [40:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ----- sv/transient_resource_pool_policy_top.sv -----
// Channel  Dir  Word
// req      in   one request: acquire, release frame, collect, drop all
// rsp      out  one result; last marks the final word of a request
// cfg      in   register index and write data; always ready
//
// Acquire: accept, 15 remainder steps, rounding, then a read and an evaluate step
// per slot scanned. Release frame and drop all: a read and an evaluate step per live
// slot. Collect: an idle pass over the slots, a full scan per budget eviction, then a
// compaction pass. Slots are read through the table memory's single read port.
// Reset clears control state; table contents stay undefined until written.
// A stalled rsp holds the scan where a word is due; req is taken only when no request is in work.
module transient_resource_pool_policy_top #(
    parameter int ENTRIES = trpp_pkg::TRPP_ENTRIES
) (
    input logic clk,
    input logic rst_n,
    trpp_req_if.sink   req,
    trpp_rsp_if.source rsp,
    trpp_cfg_if.sink   cfg
);
    import trpp_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ONE     = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_RND     = 5'd3;
    localparam logic [4:0] S_ACQ_RD  = 5'd4;
    localparam logic [4:0] S_ACQ_EV  = 5'd5;
    localparam logic [4:0] S_REL_RD  = 5'd6;
    localparam logic [4:0] S_REL_EV  = 5'd7;
    localparam logic [4:0] S_COL_RD  = 5'd8;
    localparam logic [4:0] S_COL_EV  = 5'd9;
    localparam logic [4:0] S_OV_CHK  = 5'd10;
    localparam logic [4:0] S_OV_RD   = 5'd11;
    localparam logic [4:0] S_OV_EV   = 5'd12;
    localparam logic [4:0] S_OV_RET  = 5'd13;
    localparam logic [4:0] S_CMP_RD  = 5'd14;
    localparam logic [4:0] S_CMP_EV  = 5'd15;
    localparam logic [4:0] S_DROP_RD = 5'd16;
    localparam logic [4:0] S_DROP_EV = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    entry_t        mem_wd;

    logic [4:0]  state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] fc_reg, fc_next;
    logic [38:0] total_reg, total_next;
    logic [12:0] gran_reg;
    logic [40:0] budget_reg;
    logic        early_reg;
    logic [7:0]  idle_reg;
    req_t        rq_reg, rq_next;
    logic [14:0] kw_reg, kw_next, kh_reg, kh_next;
    logic [13:0] remw_reg, remw_next, remh_reg, remh_next;
    logic [3:0]  div_reg, div_next;
    logic        skey_reg, skey_next, sbusy_reg, sbusy_next, sfl_reg, sfl_next;
    logic [ENTRIES-1:0] gone_reg, gone_next;
    logic        found_reg, found_next;
    logic [AW-1:0] best_reg, best_next;
    logic [31:0] bframe_reg, bframe_next;
    logic [34:0] bsize_reg, bsize_next;
    logic [63:0] brp_reg, brp_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    logic        out_free, emit, at_end, hit, rdy;
    rsp_t        emit_data;
    logic [13:0] tw, th;
    logic [15:0] sumw, sumh;
    logic [2:0]  cause;
    logic [AW-1:0] ia;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign at_end    = (idx_reg == count_reg);
    assign ia        = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[ia];
    end

    always_comb
    begin
        tw   = {remw_reg[12:0], rq_reg.width[div_reg]};
        th   = {remh_reg[12:0], rq_reg.height[div_reg]};
        sumw = {1'b0, rq_reg.width} + {3'b0, gran_reg} - {3'b0, remw_reg[12:0]};
        sumh = {1'b0, rq_reg.height} + {3'b0, gran_reg} - {3'b0, remh_reg[12:0]};
        hit  = (rd_data_reg.format == rq_reg.format) && (rd_data_reg.width == kw_reg)
            && (rd_data_reg.height == kh_reg) && (rd_data_reg.usage == rq_reg.usage);
        rdy  = (rd_data_reg.release_point <= rq_reg.timeline_point);
        cause = !skey_reg ? MC_NOKEY : sbusy_reg ? MC_BUSY : sfl_reg ? MC_FLIGHT : MC_OTHER;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        count_next = count_reg;
        fc_next    = fc_reg;
        total_next = total_reg;
        rq_next    = rq_reg;
        kw_next    = kw_reg;
        kh_next    = kh_reg;
        remw_next  = remw_reg;
        remh_next  = remh_reg;
        div_next   = div_reg;
        skey_next  = skey_reg;
        sbusy_next = sbusy_reg;
        sfl_next   = sfl_reg;
        gone_next  = gone_reg;
        found_next = found_reg;
        best_next  = best_reg;
        bframe_next = bframe_reg;
        bsize_next = bsize_reg;
        brp_next   = brp_reg;
        mem_we     = 1'b0;
        mem_wa     = ia;
        mem_wd     = rd_data_reg;
        emit       = 1'b0;
        emit_data  = '0;
        emit_data.last = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rq_next    = req.data;
                    idx_next   = '0;
                    skey_next  = 1'b0;
                    sbusy_next = 1'b0;
                    sfl_next   = 1'b0;
                    case (req.data.req_type)
                        REQ_ACQUIRE:
                        begin
                            if (req.data.width == '0 || req.data.height == '0)
                            begin
                                state_next = S_ONE;
                            end
                            else
                            begin
                                remw_next  = '0;
                                remh_next  = '0;
                                div_next   = 4'd14;
                                state_next = S_DIV;
                            end
                        end
                        REQ_RELEASE: state_next = S_REL_RD;
                        REQ_COLLECT:
                        begin
                            gone_next  = '0;
                            state_next = S_COL_RD;
                        end
                        default: state_next = S_DROP_RD;
                    endcase
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.status = ST_REJECT;
                    emit_data.bytes_live = total_reg;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                remw_next = (tw >= {1'b0, gran_reg}) ? tw - {1'b0, gran_reg} : tw;
                remh_next = (th >= {1'b0, gran_reg}) ? th - {1'b0, gran_reg} : th;
                div_next  = div_reg - 4'd1;
                if (div_reg == 4'd0)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if (gran_reg <= 13'd1 || remw_reg == '0)
                    kw_next = rq_reg.width;
                else
                    kw_next = (sumw > {1'b0, DIM_MAX}) ? DIM_MAX : sumw[14:0];
                if (gran_reg <= 13'd1 || remh_reg == '0)
                    kh_next = rq_reg.height;
                else
                    kh_next = (sumh > {1'b0, DIM_MAX}) ? DIM_MAX : sumh[14:0];
                state_next = S_ACQ_RD;
            end
            S_ACQ_RD:
            begin
                if (!at_end)
                begin
                    state_next = S_ACQ_EV;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.miss_cause = cause;
                    emit_data.key_width  = kw_reg;
                    emit_data.key_height = kh_reg;
                    emit_data.bytes_live = total_reg;
                    if (count_reg >= CW'(ENTRIES))
                    begin
                        emit_data.status = ST_FULL;
                    end
                    else if (!rq_reg.create_ok)
                    begin
                        emit_data.status = ST_FAILED;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wd.format = rq_reg.format;
                        mem_wd.width  = kw_reg;
                        mem_wd.height = kh_reg;
                        mem_wd.usage  = rq_reg.usage;
                        mem_wd.size   = rq_reg.image_bytes;
                        mem_wd.release_point = '0;
                        mem_wd.frame  = fc_reg;
                        mem_wd.busy   = 1'b1;
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + {4'b0, rq_reg.image_bytes};
                        emit_data.status = ST_CREATED;
                        emit_data.entry_index = 4'(idx_reg);
                        emit_data.bytes_live = total_next;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ACQ_EV:
            begin
                if (hit && !rd_data_reg.busy && (rdy || early_reg))
                begin
                    if (out_free)
                    begin
                        mem_we = 1'b1;
                        mem_wd.busy  = 1'b1;
                        mem_wd.frame = fc_reg;
                        emit = 1'b1;
                        emit_data.status = ST_REUSED;
                        emit_data.entry_index = 4'(idx_reg);
                        emit_data.unsafe_reuse = !rdy;
                        emit_data.key_width  = kw_reg;
                        emit_data.key_height = kh_reg;
                        emit_data.bytes_live = total_reg;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        skey_next = 1'b1;
                        if (rd_data_reg.busy)
                            sbusy_next = 1'b1;
                        else
                            sfl_next = 1'b1;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_ACQ_RD;
                end
            end
            S_REL_RD:
            begin
                if (!at_end)
                begin
                    state_next = S_REL_EV;
                end
                else if (out_free)
                begin
                    fc_next = fc_reg + 32'd1;
                    emit = 1'b1;
                    emit_data.status = ST_DONE;
                    emit_data.bytes_live = total_reg;
                    state_next = S_IDLE;
                end
            end
            S_REL_EV:
            begin
                if (rd_data_reg.busy)
                begin
                    mem_we = 1'b1;
                    mem_wd.busy = 1'b0;
                    mem_wd.release_point = rq_reg.timeline_point;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_REL_RD;
            end
            S_COL_RD:
            begin
                state_next = at_end ? S_OV_CHK : S_COL_EV;
            end
            S_COL_EV:
            begin
                if (!rd_data_reg.busy && (fc_reg - rd_data_reg.frame) > {24'b0, idle_reg})
                begin
                    if (out_free)
                    begin
                        total_next = total_reg - {4'b0, rd_data_reg.size};
                        gone_next[ia] = 1'b1;
                        emit = 1'b1;
                        emit_data.status = ST_RETIRED;
                        emit_data.entry_index = 4'(idx_reg);
                        emit_data.retire_point = rd_data_reg.release_point;
                        emit_data.bytes_live = total_next;
                        emit_data.last = 1'b0;
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_COL_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_COL_RD;
                end
            end
            S_OV_CHK:
            begin
                idx_next = '0;
                wr_next  = '0;
                found_next = 1'b0;
                state_next = ({2'b0, total_reg} > budget_reg) ? S_OV_RD : S_CMP_RD;
            end
            S_OV_RD:
            begin
                if (!at_end)
                    state_next = S_OV_EV;
                else if (found_reg)
                    state_next = S_OV_RET;
                else
                begin
                    idx_next   = '0;
                    state_next = S_CMP_RD;
                end
            end
            S_OV_EV:
            begin
                if (!gone_reg[ia] && !rd_data_reg.busy
                    && (!found_reg || rd_data_reg.frame < bframe_reg))
                begin
                    found_next  = 1'b1;
                    best_next   = ia;
                    bframe_next = rd_data_reg.frame;
                    bsize_next  = rd_data_reg.size;
                    brp_next    = rd_data_reg.release_point;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_OV_RD;
            end
            S_OV_RET:
            begin
                if (out_free)
                begin
                    total_next = total_reg - {4'b0, bsize_reg};
                    gone_next[best_reg] = 1'b1;
                    emit = 1'b1;
                    emit_data.status = ST_RETIRED;
                    emit_data.entry_index = 4'(best_reg);
                    emit_data.retire_point = brp_reg;
                    emit_data.bytes_live = total_next;
                    emit_data.last = 1'b0;
                    state_next = S_OV_CHK;
                end
            end
            S_CMP_RD:
            begin
                if (at_end)
                begin
                    count_next = wr_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CMP_EV;
                end
            end
            S_CMP_EV:
            begin
                if (!gone_reg[ia])
                begin
                    mem_we  = 1'b1;
                    mem_wa  = wr_reg[AW-1:0];
                    wr_next = wr_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_CMP_RD;
            end
            S_DROP_RD:
            begin
                if (at_end)
                begin
                    count_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DROP_EV;
                end
            end
            S_DROP_EV:
            begin
                if (out_free)
                begin
                    total_next = total_reg - {4'b0, rd_data_reg.size};
                    emit = 1'b1;
                    emit_data.status = ST_RETIRED;
                    emit_data.entry_index = 4'(idx_reg);
                    emit_data.retire_point = rd_data_reg.release_point;
                    emit_data.bytes_live = total_next;
                    emit_data.last = 1'b0;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_DROP_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.status = ST_DONE;
                    emit_data.bytes_live = total_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next = emit_data;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fc_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            gran_reg      <= GRAN_RESET;
            budget_reg    <= BUDGET_RESET;
            early_reg     <= 1'b0;
            idle_reg      <= IDLE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fc_reg        <= fc_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.addr)
                    REG_GRANULARITY: gran_reg   <= cfg.wdata[12:0];
                    REG_BUDGET:      budget_reg <= cfg.wdata;
                    REG_EARLY:       early_reg  <= cfg.wdata[0];
                    REG_IDLE:        idle_reg   <= cfg.wdata[7:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        wr_reg     <= wr_next;
        rq_reg     <= rq_next;
        kw_reg     <= kw_next;
        kh_reg     <= kh_next;
        remw_reg   <= remw_next;
        remh_reg   <= remh_next;
        div_reg    <= div_next;
        skey_reg   <= skey_next;
        sbusy_reg  <= sbusy_next;
        sfl_reg    <= sfl_next;
        gone_reg   <= gone_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bframe_reg <= bframe_next;
        bsize_reg  <= bsize_next;
        brp_reg    <= brp_next;
        out_reg    <= out_next;
    end

endmodule

// ----- sv/trpp_checker.sv -----
`include "assert_macros.svh"

module trpp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic       rsp_last
);
    import trpp_pkg::*;

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
    `ASSERT_NEXT(a_one_req, clk, rst_n, req_valid && req_ready, !req_ready, "req taken twice")
    `ASSERT_IMPL(a_retire_mid, clk, rst_n, rsp_valid && rsp_status == ST_RETIRED, !rsp_last, "retire marked last")
    `ASSERT_IMPL(a_other_last, clk, rst_n, rsp_valid && rsp_status != ST_RETIRED, rsp_last, "final word not last")

endmodule

bind transient_resource_pool_policy_top trpp_checker u_trpp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_last   (rsp.data.last)
);
